### rtl/eil4_pkg.sv
// Shared types, header offsets and read schedule for the IPv4 L4 header extractor.
package eil4_pkg;

  // Sequencer step counter.
  typedef logic [4:0] step_t;

  // Ethernet and IPv4 constants.
  localparam logic [7:0] ETYPE_HI_IPV4 = 8'h08;
  localparam logic [7:0] ETYPE_LO_IPV4 = 8'h00;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [7:0] PROTO_TCP     = 8'd6;

  // Frame byte offsets of the fixed header fields.
  localparam logic [7:0] BYTE_ETYPE_HI = 8'd12;
  localparam logic [7:0] BYTE_ETYPE_LO = 8'd13;
  localparam logic [7:0] BYTE_VER_IHL  = 8'd14;
  localparam logic [7:0] BYTE_PROTO    = 8'd23;
  localparam logic [7:0] BYTE_ADDR     = 8'd26;
  localparam logic [7:0] L2_HDR_BYTES  = 8'd14;
  localparam logic [7:0] TCP_OFF_BYTE  = 8'd12;

  // Minimum transport header sizes.
  localparam logic [9:0] UDP_HDR_BYTES = 10'd8;
  localparam logic [9:0] TCP_HDR_BYTES = 10'd20;

  // Frame length limits, held as the index of the final byte.
  localparam logic [9:0] MIN_ETH_LAST  = 10'd13;
  localparam logic [9:0] MIN_IP_LAST   = 10'd33;

  // Steps at which reads are issued.
  localparam step_t RD_ETYPE_HI = 5'd0;
  localparam step_t RD_ETYPE_LO = 5'd1;
  localparam step_t RD_VER_IHL  = 5'd2;
  localparam step_t RD_PROTO    = 5'd3;
  localparam step_t RD_ADDR     = 5'd4;
  localparam step_t RD_ADDR_END = 5'd11;
  localparam step_t RD_L4       = 5'd12;
  localparam step_t RD_L4_END   = 5'd17;
  localparam step_t RD_TCP_OFF  = 5'd18;

  // Steps at which the read data for each field is present.
  localparam step_t DT_ETYPE_HI  = 5'd1;
  localparam step_t DT_ETYPE_LO  = 5'd2;
  localparam step_t DT_VER_IHL   = 5'd3;
  localparam step_t DT_PROTO     = 5'd4;
  localparam step_t DT_SRC_FIRST = 5'd5;
  localparam step_t DT_SRC_LAST  = 5'd8;
  localparam step_t DT_DST_FIRST = 5'd9;
  localparam step_t DT_DST_LAST  = 5'd12;
  localparam step_t DT_SP_FIRST  = 5'd13;
  localparam step_t DT_SP_LAST   = 5'd14;
  localparam step_t DT_DP_FIRST  = 5'd15;
  localparam step_t DT_DP_LAST   = 5'd16;
  localparam step_t DT_UL_FIRST  = 5'd17;
  localparam step_t DT_UL_LAST   = 5'd18;
  localparam step_t LAST_STEP    = 5'd19;

  // Frame byte index read at a given step; the transport offset follows IHL.
  function automatic logic [7:0] read_index(input step_t step, input logic [3:0] ihl);
    logic [7:0] toff;
    logic [7:0] idx;
    toff = L2_HDR_BYTES + {2'b00, ihl, 2'b00};
    case (step) inside
      RD_ETYPE_HI:              idx = BYTE_ETYPE_HI;
      RD_ETYPE_LO:              idx = BYTE_ETYPE_LO;
      RD_VER_IHL:               idx = BYTE_VER_IHL;
      RD_PROTO:                 idx = BYTE_PROTO;
      [RD_ADDR:RD_ADDR_END]:    idx = BYTE_ADDR + {3'b000, step - RD_ADDR};
      [RD_L4:RD_L4_END]:        idx = toff + {3'b000, step - RD_L4};
      RD_TCP_OFF:               idx = toff + TCP_OFF_BYTE;
      default:                  idx = BYTE_ETYPE_HI;
    endcase
    return idx;
  endfunction

endpackage

### rtl/eth_ipv4_l4_header_extractor.sv
// Ethernet IPv4 UDP/TCP header extractor with a ping-pong header capture memory.
//
// Input channel: one frame byte per request (in_data_byte), in_last_byte on
// the final byte, and in_time_ns, which is sampled on the frame's first byte.
// Result channel: one request per frame, with the pass/drop verdict and, for
// IPv4 UDP and TCP frames, the addresses, ports, a length and the frame time.
//
// Each frame's leading bytes are written into one half of a capture memory
// while the previous frame is parsed from the other half. After the final
// byte, a sequencer reads 19 header bytes, one per cycle through the single
// read port, and loads the result register on its last step once the
// register is free. Bytes are accepted back to back, one per cycle; only a
// final byte that arrives while the previous frame is still being parsed is
// stalled, so a short frame waits at its final byte until that parse is done.
//
// Reset clears the byte count, the sampled time, the sequencer and the
// result valid flag; the capture memory is not cleared. When the receiver
// stalls, the result is held; parsing of the next frame runs up to its last
// step and then waits for the result register to free up.
module eth_ipv4_l4_header_extractor #(
  parameter int CAPTURE_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [63:0] in_time_ns,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_verdict,
  output logic        out_reported,
  output logic        out_protocol_kind,
  output logic [31:0] out_source_address,
  output logic [31:0] out_dest_address,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic [15:0] out_length_value,
  output logic [63:0] out_frame_time
);

  localparam int PW        = $clog2(CAPTURE_BYTES);
  localparam int PCW       = $clog2(CAPTURE_BYTES + 1);
  localparam int MEM_DEPTH = 2 ** (PW + 1);

  // Capture memory: two halves, selected by the top address bit.
  logic [7:0] hdr_mem [MEM_DEPTH];

  logic [PCW-1:0]      pos_r;
  logic [63:0]         start_time_r;
  logic                cur_bank_r;
  logic                job_active_r;
  logic                job_bank_r;
  eil4_pkg::step_t     step_r;
  logic [PCW-1:0]      job_pos_r;
  logic [63:0]         job_time_r;
  logic [7:0]          rd_data_r;
  logic [7:0]          etype_hi_r;
  logic [7:0]          etype_lo_r;
  logic [3:0]          ihl_r;
  logic [7:0]          proto_r;
  logic [31:0]         src_r;
  logic [31:0]         dst_r;
  logic [15:0]         sport_r;
  logic [15:0]         dport_r;
  logic [15:0]         ulen_r;

  logic                out_valid_r;
  logic                verdict_r;
  logic                reported_r;
  logic                kind_r;
  logic [31:0]         src_out_r;
  logic [31:0]         dst_out_r;
  logic [15:0]         sport_out_r;
  logic [15:0]         dport_out_r;
  logic [15:0]         len_out_r;
  logic [63:0]         time_out_r;

  logic                in_accept;
  logic                last_accept;
  logic                wr_en;
  logic [PW:0]         wr_addr;
  logic                rd_en;
  logic [7:0]          rd_idx;
  logic [PW:0]         rd_addr;
  logic                out_load;

  // A final byte waits while the previous frame is still being parsed.
  assign in_stall    = job_active_r && in_last_byte;
  assign in_accept   = in_valid && !in_stall;
  assign last_accept = in_accept && in_last_byte;

  // Byte write into the current half while the position is inside the capture.
  assign wr_en   = in_accept && (pos_r < PCW'(CAPTURE_BYTES));
  assign wr_addr = {cur_bank_r, pos_r[PW-1:0]};

  // Header reads are issued on every step before the last.
  assign rd_en   = job_active_r && (step_r < eil4_pkg::LAST_STEP);
  assign rd_idx  = eil4_pkg::read_index(step_r, ihl_r);
  assign rd_addr = {job_bank_r, PW'(rd_idx)};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hdr_mem[wr_addr] <= in_data_byte;
    end
    if (rd_en) begin
      rd_data_r <= hdr_mem[rd_addr];
    end
  end

  // Byte position, sampled time and half selection for the incoming frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      start_time_r <= '0;
      cur_bank_r   <= 1'b0;
    end else if (in_accept) begin
      if (pos_r == '0) begin
        start_time_r <= in_time_ns;
      end
      if (in_last_byte) begin
        pos_r      <= '0;
        cur_bank_r <= !cur_bank_r;
      end else if (pos_r < PCW'(CAPTURE_BYTES)) begin
        pos_r <= pos_r + PCW'(1);
      end
    end
  end

  // Parse sequencer: starts on a final byte and ends when the result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_active_r <= 1'b0;
      step_r       <= '0;
    end else if (last_accept) begin
      job_active_r <= 1'b1;
      step_r       <= '0;
    end else if (job_active_r) begin
      if (step_r < eil4_pkg::LAST_STEP) begin
        step_r <= step_r + 5'd1;
      end else if (out_load) begin
        job_active_r <= 1'b0;
      end
    end
  end

  // Frame descriptor held for the sequencer.
  always_ff @(posedge clk) begin
    if (last_accept) begin
      job_bank_r <= cur_bank_r;
      job_pos_r  <= pos_r;
      job_time_r <= (pos_r == '0) ? in_time_ns : start_time_r;
    end
  end

  // Field capture from the read data of the previous step.
  always_ff @(posedge clk) begin
    if (job_active_r) begin
      case (step_r) inside
        eil4_pkg::DT_ETYPE_HI: etype_hi_r <= rd_data_r;
        eil4_pkg::DT_ETYPE_LO: etype_lo_r <= rd_data_r;
        eil4_pkg::DT_VER_IHL:  ihl_r      <= rd_data_r[3:0];
        eil4_pkg::DT_PROTO:    proto_r    <= rd_data_r;
        [eil4_pkg::DT_SRC_FIRST:eil4_pkg::DT_SRC_LAST]: src_r   <= {src_r[23:0], rd_data_r};
        [eil4_pkg::DT_DST_FIRST:eil4_pkg::DT_DST_LAST]: dst_r   <= {dst_r[23:0], rd_data_r};
        [eil4_pkg::DT_SP_FIRST:eil4_pkg::DT_SP_LAST]:   sport_r <= {sport_r[7:0], rd_data_r};
        [eil4_pkg::DT_DP_FIRST:eil4_pkg::DT_DP_LAST]:   dport_r <= {dport_r[7:0], rd_data_r};
        [eil4_pkg::DT_UL_FIRST:eil4_pkg::DT_UL_LAST]:   ulen_r  <= {ulen_r[7:0], rd_data_r};
        default: ;
      endcase
    end
  end

  // Verdict on the last step; the TCP offset byte is still in the read register.
  logic [9:0]  last_idx;
  logic [9:0]  frame_len;
  logic [9:0]  toff;
  logic        is_udp;
  logic        is_tcp;
  logic        is_ipv4;
  logic        cut_l4;
  logic        res_verdict;
  logic        res_reported;

  always_comb begin
    last_idx     = 10'(job_pos_r);
    frame_len    = last_idx + 10'd1;
    toff         = 10'(eil4_pkg::L2_HDR_BYTES) + {4'b0000, ihl_r, 2'b00};
    is_udp       = (proto_r == eil4_pkg::PROTO_UDP);
    is_tcp       = (proto_r == eil4_pkg::PROTO_TCP);
    is_ipv4      = (last_idx >= eil4_pkg::MIN_ETH_LAST) &&
                   (etype_hi_r == eil4_pkg::ETYPE_HI_IPV4) &&
                   (etype_lo_r == eil4_pkg::ETYPE_LO_IPV4) &&
                   (last_idx >= eil4_pkg::MIN_IP_LAST);
    cut_l4       = (toff + (is_udp ? eil4_pkg::UDP_HDR_BYTES : eil4_pkg::TCP_HDR_BYTES))
                   > frame_len;
    res_verdict  = is_ipv4 && (is_udp || is_tcp) && cut_l4;
    res_reported = is_ipv4 && (is_udp || is_tcp) && !cut_l4;
  end

  assign out_load = job_active_r && (step_r == eil4_pkg::LAST_STEP) &&
                    (!out_valid_r || !out_stall);

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      verdict_r   <= res_verdict;
      reported_r  <= res_reported;
      kind_r      <= res_reported && is_tcp;
      src_out_r   <= res_reported ? src_r : '0;
      dst_out_r   <= res_reported ? dst_r : '0;
      sport_out_r <= res_reported ? sport_r : '0;
      dport_out_r <= res_reported ? dport_r : '0;
      if (!res_reported) begin
        len_out_r <= '0;
      end else if (is_udp) begin
        len_out_r <= ulen_r;
      end else begin
        len_out_r <= {10'b0, rd_data_r[7:4], 2'b00};
      end
      time_out_r  <= res_reported ? job_time_r : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = verdict_r;
  assign out_reported       = reported_r;
  assign out_protocol_kind  = kind_r;
  assign out_source_address = src_out_r;
  assign out_dest_address   = dst_out_r;
  assign out_source_port    = sport_out_r;
  assign out_dest_port      = dport_out_r;
  assign out_length_value   = len_out_r;
  assign out_frame_time     = time_out_r;

`ifndef SYNTHESIS
  // The parsed half is never the half being written.
  a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
    job_active_r |-> (cur_bank_r != job_bank_r))
    else $error("capture write targets the half under parse");

  // The sequencer never runs past its last step.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_active_r |-> (step_r <= eil4_pkg::LAST_STEP))
    else $error("parse step out of range");

  // A new result only comes from the last parse step.
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(job_active_r && (step_r == eil4_pkg::LAST_STEP)))
    else $error("result loaded outside the last parse step");

  // A dropped frame is never reported.
  a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(reported_r && verdict_r))
    else $error("result both dropped and reported");

  // Unreported results carry zero fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !reported_r) |->
      ((src_out_r == '0) && (len_out_r == '0) && (time_out_r == '0) && !kind_r))
    else $error("unreported result carries header fields");
`endif

endmodule
